### hw/rtl/svt_pkg.sv
// ----------------------------------------------------------------------------
// Shear viscosity tensor package
// Shared widths, constants, beat structs and the Q.30 multiply helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svt_pkg;

   // Q.30 working width for metric, projector and trace terms
   localparam int QW      = 40;
   // clamped numerator width (Q.30, magnitude below 2^36)
   localparam int NUMW    = 38;
   // quotient bits produced by the divider and bits retired per stage
   localparam int QBITS   = 40;
   localparam int STEPS   = 2;
   localparam int DIV_STAGES = QBITS / STEPS;
   // divider remainder width: holds the divisor shifted by QBITS-1
   localparam int RW      = 80;
   // signed correction width
   localparam int CW      = QBITS + 1;
   // floored symmetric term, Q.26
   localparam int SYMW    = 28;
   // tensor entry width and entry count
   localparam int KW      = 48;
   localparam int NK      = 9;

   typedef logic signed [QW-1:0]   q_type;
   typedef logic signed [SYMW-1:0] sym_type;
   typedef logic signed [KW-1:0]   k_type;

   localparam q_type ONE_Q30 = 40'sd1073741824;
   localparam q_type NUM_LIM = 40'sd68719476735;

   // Front end result handed to the divider
   typedef struct packed {
      logic [NK-1:0][NUMW-1:0] num;
      logic [QW-1:0]           dvs;
      logic [NK-1:0][SYMW-1:0] sym;
      logic [63:0]             eta;
      logic                    degen;
   } front_type;

   // Divider result handed to the output scaler
   typedef struct packed {
      logic [NK-1:0][CW-1:0]   corr;
      logic [NK-1:0][SYMW-1:0] sym;
      logic [63:0]             eta;
      logic                    degen;
   } quot_type;

   // Floor of a*b / 2^30
   function automatic q_type mul30(input q_type a, input q_type b);
      logic signed [2*QW-1:0] p;
      p = a * b;
      return p[QW+29:30];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/svt_req_if.sv
// ----------------------------------------------------------------------------
// Shear viscosity request channel
// Valid/ready channel carrying one cell's velocity, sound speed and entropy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface svt_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic [15:0]        sound_speed_sq;
   logic [31:0]        entropy_density;

   modport source (output valid, output vel_x, output vel_y, output sound_speed_sq,
                   output entropy_density, input ready);
   modport sink   (input valid, input vel_x, input vel_y, input sound_speed_sq,
                   input entropy_density, output ready);
endinterface

`default_nettype wire

### hw/rtl/svt_rsp_if.sv
// ----------------------------------------------------------------------------
// Shear viscosity response channel
// Valid/ready channel carrying the nine tensor entries and the degenerate flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface svt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] k_xx_xx;
   logic signed [47:0] k_xx_xy;
   logic signed [47:0] k_xx_yy;
   logic signed [47:0] k_xy_xx;
   logic signed [47:0] k_xy_xy;
   logic signed [47:0] k_xy_yy;
   logic signed [47:0] k_yy_xx;
   logic signed [47:0] k_yy_xy;
   logic signed [47:0] k_yy_yy;
   logic               degenerate;

   modport source (output valid, output k_xx_xx, output k_xx_xy, output k_xx_yy,
                   output k_xy_xx, output k_xy_xy, output k_xy_yy, output k_yy_xx,
                   output k_yy_xy, output k_yy_yy, output degenerate, input ready);
   modport sink   (input valid, input k_xx_xx, input k_xx_xy, input k_xx_yy,
                   input k_xy_xx, input k_xy_xy, input k_xy_yy, input k_yy_xx,
                   input k_yy_xy, input k_yy_yy, input degenerate, output ready);
endinterface

`default_nettype wire

### hw/rtl/svt_front.sv
// ----------------------------------------------------------------------------
// Shear viscosity front end
// Seven stages: metric, projector, traces, hPh and the clamped numerators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svt_front
   import svt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [15:0] vel_x,
   input  logic signed [15:0] vel_y,
   input  logic [15:0]        sound_speed_sq,
   input  logic [31:0]        entropy_density,
   input  logic [31:0]        visc_ratio,
   output logic               out_valid,
   output front_type          out_data
);

   localparam int NSTG = 7;

   logic [NSTG-1:0]    vld_ff, vld_in;
   logic [63:0]        eta_ff [NSTG];
   logic [63:0]        eta1_in;

   logic signed [31:0] q1_ff [3], q1_in [3];
   logic [15:0]        cs1_ff;

   q_type   h2_ff [3], h2_in [3], p2_ff [3], p2_in [3];
   q_type   h3_ff [3], p3_ff [3], t3_ff [4], t3_in [4], ph3_ff, ph3_in;
   q_type   h4_ff [3], p4_ff [3], ph4_ff, hph4_ff [4], hph4_in [4];
   q_type   d4_ff, d4_in, b4_ff [3], b4_in [3];
   q_type   h5_ff [3], d5_ff, phph5_ff, phph5_in, a5_ff [3], a5_in [3];
   q_type   c5_ff [NK], c5_in [NK];
   logic    degen5_ff, degen5_in;
   q_type   h6_ff [3], d6_ff, n6_ff [NK], n6_in [NK];
   sym_type sym6_ff [NK], sym6_in [NK];
   logic    degen6_ff;
   logic signed [NUMW-1:0] num7_ff [NK], num7_in [NK];
   q_type   d7_ff;
   sym_type sym7_ff [NK];
   logic    degen7_ff;

   assign vld_in = {vld_ff[NSTG-2:0], in_valid};

   // Stage 1: velocity products and eta
   always_comb begin
      q1_in[0] = vel_x * vel_x;
      q1_in[1] = vel_x * vel_y;
      q1_in[2] = vel_y * vel_y;
      eta1_in  = 64'(visc_ratio) * 64'(entropy_density);
   end

   // Stage 2: metric h and projector P (both symmetric, three distinct entries)
   always_comb begin
      logic signed [47:0] pn;
      h2_in[0] = ONE_Q30 - q_type'(q1_ff[0]);
      h2_in[1] = -q_type'(q1_ff[1]);
      h2_in[2] = ONE_Q30 - q_type'(q1_ff[2]);
      for (int i = 0; i < 3; i++) begin
         pn = (48'(h2_in[i]) <<< 15) - (48'($signed({1'b0, cs1_ff})) * 48'(q1_ff[i]));
         p2_in[i] = q_type'(pn >>> 16);
      end
   end

   // Stage 3: trace Ph and T = h P
   always_comb begin
      ph3_in   = mul30(p2_ff[0], h2_ff[0]) + mul30(p2_ff[1], h2_ff[1])
               + mul30(p2_ff[1], h2_ff[1]) + mul30(p2_ff[2], h2_ff[2]);
      t3_in[0] = mul30(h2_ff[0], p2_ff[0]) + mul30(h2_ff[1], p2_ff[1]);
      t3_in[1] = mul30(h2_ff[0], p2_ff[1]) + mul30(h2_ff[1], p2_ff[2]);
      t3_in[2] = mul30(h2_ff[1], p2_ff[0]) + mul30(h2_ff[2], p2_ff[1]);
      t3_in[3] = mul30(h2_ff[1], p2_ff[1]) + mul30(h2_ff[2], p2_ff[2]);
   end

   // Stage 4: hPh = T h, squared trace, h_mn * Ph
   always_comb begin
      hph4_in[0] = mul30(t3_ff[0], h3_ff[0]) + mul30(t3_ff[1], h3_ff[1]);
      hph4_in[1] = mul30(t3_ff[0], h3_ff[1]) + mul30(t3_ff[1], h3_ff[2]);
      hph4_in[2] = mul30(t3_ff[2], h3_ff[0]) + mul30(t3_ff[3], h3_ff[1]);
      hph4_in[3] = mul30(t3_ff[2], h3_ff[1]) + mul30(t3_ff[3], h3_ff[2]);
      d4_in      = mul30(ph3_ff, ph3_ff);
      for (int i = 0; i < 3; i++) begin
         b4_in[i] = mul30(h3_ff[i], ph3_ff);
      end
   end

   // Stage 5: PhPh, Ph*hPh_mn and (h_mn*Ph)*hPh_ij
   always_comb begin
      phph5_in = mul30(p4_ff[0], hph4_ff[0]) + mul30(p4_ff[1], hph4_ff[1])
               + mul30(p4_ff[1], hph4_ff[2]) + mul30(p4_ff[2], hph4_ff[3]);
      for (int r = 0; r < 3; r++) begin
         a5_in[r] = mul30(ph4_ff, hph4_ff[(r == 2) ? 3 : r]);
      end
      for (int p = 0; p < 3; p++) begin
         for (int r = 0; r < 3; r++) begin
            c5_in[p*3+r] = mul30(b4_ff[r], hph4_ff[(p == 2) ? 3 : p]);
         end
      end
      degen5_in = (d4_ff == '0);
   end

   // Stage 6: bracket N and the floored symmetric term
   always_comb begin
      logic signed [63:0] s;
      for (int p = 0; p < 3; p++) begin
         for (int r = 0; r < 3; r++) begin
            n6_in[p*3+r] = a5_ff[r] - c5_ff[p*3+r] + phph5_ff;
            // h index is the sum of its two coordinates, h_xy equals h_yx
            s = ($signed(h5_ff[((p == 2) ? 1 : 0) + ((r == 2) ? 1 : 0)][31:0])
                 * $signed(h5_ff[((p != 0) ? 1 : 0) + ((r != 0) ? 1 : 0)][31:0]))
              + ($signed(h5_ff[((p == 2) ? 1 : 0) + ((r != 0) ? 1 : 0)][31:0])
                 * $signed(h5_ff[((p != 0) ? 1 : 0) + ((r == 2) ? 1 : 0)][31:0]));
            sym6_in[p*3+r] = sym_type'(s >>> 35);
         end
      end
   end

   // Stage 7: numerator h_ij * N, clamped
   always_comb begin
      q_type t;
      for (int p = 0; p < 3; p++) begin
         for (int r = 0; r < 3; r++) begin
            t = mul30(h6_ff[((p == 2) ? 1 : 0) + ((p != 0) ? 1 : 0)], n6_ff[p*3+r]);
            priority if (t > NUM_LIM) begin
               num7_in[p*3+r] = NUMW'(NUM_LIM);
            end else if (t < -NUM_LIM) begin
               num7_in[p*3+r] = NUMW'(-NUM_LIM);
            end else begin
               num7_in[p*3+r] = NUMW'(t);
            end
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         eta_ff[0] <= eta1_in;
         for (int s = 1; s < NSTG; s++) begin
            eta_ff[s] <= eta_ff[s-1];
         end
         q1_ff    <= q1_in;
         cs1_ff   <= sound_speed_sq;
         h2_ff    <= h2_in;
         p2_ff    <= p2_in;
         h3_ff    <= h2_ff;
         p3_ff    <= p2_ff;
         t3_ff    <= t3_in;
         ph3_ff   <= ph3_in;
         h4_ff    <= h3_ff;
         p4_ff    <= p3_ff;
         ph4_ff   <= ph3_ff;
         hph4_ff  <= hph4_in;
         d4_ff    <= d4_in;
         b4_ff    <= b4_in;
         h5_ff    <= h4_ff;
         d5_ff    <= d4_ff;
         phph5_ff <= phph5_in;
         a5_ff    <= a5_in;
         c5_ff    <= c5_in;
         degen5_ff <= degen5_in;
         h6_ff    <= h5_ff;
         d6_ff    <= d5_ff;
         n6_ff    <= n6_in;
         sym6_ff  <= sym6_in;
         degen6_ff <= degen5_ff;
         num7_ff  <= num7_in;
         d7_ff    <= d6_ff;
         sym7_ff  <= sym6_ff;
         degen7_ff <= degen6_ff;
      end
   end

   // Pack the beat for the divider
   always_comb begin
      for (int k = 0; k < NK; k++) begin
         out_data.num[k] = num7_ff[k];
         out_data.sym[k] = sym7_ff[k];
      end
      out_data.dvs   = d7_ff;
      out_data.eta   = eta_ff[NSTG-1];
      out_data.degen = degen7_ff;
   end

   assign out_valid = vld_ff[NSTG-1];

endmodule

`default_nettype wire

### hw/rtl/svt_div.sv
// ----------------------------------------------------------------------------
// Shear viscosity correction divider
// Nine restoring division lanes sharing one divisor, two quotient bits a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svt_div
   import svt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  front_type in_data,
   output logic      out_valid,
   output quot_type  out_data
);

   typedef struct packed {
      logic [NK-1:0][RW-1:0]    rem;
      logic [NK-1:0][QBITS-1:0] quo;
      logic [NK-1:0]            neg;
      logic [QW-1:0]            dvs;
      logic [NK-1:0][SYMW-1:0]  sym;
      logic [63:0]              eta;
      logic                     degen;
   } div_stage_type;

   logic [DIV_STAGES-1:0] vld_ff, vld_in;
   div_stage_type         st_ff [DIV_STAGES];
   div_stage_type         st_in [DIV_STAGES];
   div_stage_type         src   [DIV_STAGES];

   assign vld_in = {vld_ff[DIV_STAGES-2:0], in_valid};

   // Load magnitudes, then retire quotient bits from the top down
   always_comb begin
      div_stage_type   cur;
      logic [NUMW-1:0] mag;
      logic [RW-1:0]   cand;
      int              b;
      src[0].dvs   = in_data.dvs;
      src[0].sym   = in_data.sym;
      src[0].eta   = in_data.eta;
      src[0].degen = in_data.degen;
      for (int k = 0; k < NK; k++) begin
         src[0].neg[k] = in_data.num[k][NUMW-1];
         mag = in_data.num[k][NUMW-1] ? (~in_data.num[k] + 1'b1) : in_data.num[k];
         src[0].rem[k] = RW'(mag) << 26;
         src[0].quo[k] = '0;
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
         src[s] = st_ff[s-1];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         cur = src[s];
         for (int k = 0; k < NK; k++) begin
            for (int j = 0; j < STEPS; j++) begin
               b = QBITS - 1 - (s * STEPS + j);
               cand = RW'(cur.dvs) << b;
               if (cur.rem[k] >= cand) begin
                  cur.rem[k]    = cur.rem[k] - cand;
                  cur.quo[k][b] = 1'b1;
               end
            end
         end
         st_in[s] = cur;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Advance lanes
   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   // Restore the sign, truncating toward zero
   always_comb begin
      for (int k = 0; k < NK; k++) begin
         out_data.corr[k] = st_ff[DIV_STAGES-1].neg[k]
                          ? (~{1'b0, st_ff[DIV_STAGES-1].quo[k]} + 1'b1)
                          : {1'b0, st_ff[DIV_STAGES-1].quo[k]};
      end
      out_data.sym   = st_ff[DIV_STAGES-1].sym;
      out_data.eta   = st_ff[DIV_STAGES-1].eta;
      out_data.degen = st_ff[DIV_STAGES-1].degen;
   end

   assign out_valid = vld_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

### hw/rtl/svt_back.sv
// ----------------------------------------------------------------------------
// Shear viscosity output scaler
// Forms X = sym - corr, scales by eta in two halves and saturates to Q24.24.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svt_back
   import svt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  quot_type in_data,
   output logic     out_valid,
   output k_type    k_out [NK],
   output logic     degen_out
);

   localparam int XW = CW + 1;
   localparam int HW = XW + 33;
   localparam int PW = XW + 65;
   localparam k_type K_MAX = {1'b0, {(KW-1){1'b1}}};
   localparam k_type K_MIN = {1'b1, {(KW-1){1'b0}}};

   logic [2:0] vld_ff, vld_in;

   logic signed [XW-1:0] x1_ff [NK], x1_in [NK];
   logic [63:0]          eta1_ff;
   logic                 degen1_ff;
   logic signed [HW-1:0] lo2_ff [NK], lo2_in [NK], hi2_ff [NK], hi2_in [NK];
   logic                 degen2_ff;
   k_type                k3_ff [NK], k3_in [NK];
   logic                 degen3_ff;

   assign vld_in = {vld_ff[1:0], in_valid};

   // X in Q.26
   always_comb begin
      for (int k = 0; k < NK; k++) begin
         x1_in[k] = XW'($signed(in_data.sym[k])) - XW'($signed(in_data.corr[k]));
      end
   end

   // Partial products against the low and high halves of eta
   always_comb begin
      for (int k = 0; k < NK; k++) begin
         lo2_in[k] = HW'(x1_ff[k]) * HW'($signed({1'b0, eta1_ff[31:0]}));
         hi2_in[k] = HW'(x1_ff[k]) * HW'($signed({1'b0, eta1_ff[63:32]}));
      end
   end

   // Combine, floor by 2^41, saturate; zero on a degenerate cell
   always_comb begin
      logic signed [PW-1:0] full;
      logic signed [PW-1:0] sh;
      for (int k = 0; k < NK; k++) begin
         full = (PW'(hi2_ff[k]) <<< 32) + PW'(lo2_ff[k]);
         sh   = full >>> 41;
         priority if (degen2_ff) begin
            k3_in[k] = '0;
         end else if (sh > PW'(K_MAX)) begin
            k3_in[k] = K_MAX;
         end else if (sh < PW'(K_MIN)) begin
            k3_in[k] = K_MIN;
         end else begin
            k3_in[k] = KW'(sh);
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff     <= x1_in;
         eta1_ff   <= in_data.eta;
         degen1_ff <= in_data.degen;
         lo2_ff    <= lo2_in;
         hi2_ff    <= hi2_in;
         degen2_ff <= degen1_ff;
         k3_ff     <= k3_in;
         degen3_ff <= degen2_ff;
      end
   end

   assign out_valid = vld_ff[2];
   assign k_out     = k3_ff;
   assign degen_out = degen3_ff;

endmodule

`default_nettype wire

### hw/rtl/shear_viscosity_tensor_2d_unit.sv
// ----------------------------------------------------------------------------
// Shear viscosity tensor unit, 2-D
// Pipeline: 7 front stages, 20 divider stages at two quotient bits each and
//   3 scaling stages, from request beat to response beat.
// Throughput: one cell per cycle; the whole pipe holds while the response
//   register is full and not taken.
// Reset clears all valid bits and loads the viscosity ratio with its default.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shear_viscosity_tensor_2d_unit
   import svt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   svt_req_if.sink     req_if,
   svt_rsp_if.source   rsp_if
);

   localparam logic [31:0] VISC_RATIO_RST = 32'd1342177;

   logic [31:0] visc_ratio_ff;
   logic        en;
   logic        front_vld, div_vld, back_vld;
   front_type   front_data;
   quot_type    div_data;
   k_type       k_res [NK];
   logic        degen_res;

   // Hold the viscosity ratio register
   always_ff @(posedge clock) begin
      if (reset) begin
         visc_ratio_ff <= VISC_RATIO_RST;
      end else if (csr_wr_en) begin
         visc_ratio_ff <= csr_wr_data;
      end
   end

   // Advance the pipe whenever the response register is free or drains
   assign en           = !back_vld || rsp_if.ready;
   assign req_if.ready = en;

   svt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req_if.valid),
      .vel_x           (req_if.vel_x),
      .vel_y           (req_if.vel_y),
      .sound_speed_sq  (req_if.sound_speed_sq),
      .entropy_density (req_if.entropy_density),
      .visc_ratio      (visc_ratio_ff),
      .out_valid       (front_vld),
      .out_data        (front_data)
   );

   svt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_vld),
      .in_data   (front_data),
      .out_valid (div_vld),
      .out_data  (div_data)
   );

   svt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_vld),
      .in_data   (div_data),
      .out_valid (back_vld),
      .k_out     (k_res),
      .degen_out (degen_res)
   );

   // Drive the response beat
   assign rsp_if.valid      = back_vld;
   assign rsp_if.k_xx_xx    = k_res[0];
   assign rsp_if.k_xx_xy    = k_res[1];
   assign rsp_if.k_xx_yy    = k_res[2];
   assign rsp_if.k_xy_xx    = k_res[3];
   assign rsp_if.k_xy_xy    = k_res[4];
   assign rsp_if.k_xy_yy    = k_res[5];
   assign rsp_if.k_yy_xx    = k_res[6];
   assign rsp_if.k_yy_xy    = k_res[7];
   assign rsp_if.k_yy_yy    = k_res[8];
   assign rsp_if.degenerate = degen_res;

endmodule

`default_nettype wire

### tb/shear_viscosity_tensor_2d_unit_tb.sv
// ----------------------------------------------------------------------------
// Shear viscosity tensor unit testbench
// Streams cells through the unit under several pacing mixes and viscosity
// ratio settings. Each response beat is checked entry by entry against an
// exact fixed-point predictor of the tensor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shear_viscosity_tensor_2d_unit_tb
   import svt_pkg::*;
();

   localparam int  CYCLE_LIMIT  = 300000;
   localparam int  DRAIN_CYCLES = 40;
   localparam logic [31:0] ETA_RESET = 32'd1342177;

   typedef struct {
      k_type k[NK];
      logic  degen;
   } tensor_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [31:0] csr_wr_data;

   svt_req_if req_bus();
   svt_rsp_if rsp_bus();

   shear_viscosity_tensor_2d_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus)
   );

   tensor_type  tensor_q[$];
   logic [31:0] visc_ratio_shadow = ETA_RESET;
   int          idle_pct  = 0;
   int          stall_pct = 0;
   int          hold_len  = 0;
   int          errors    = 0;
   int          cells_sent = 0;
   int          beats_checked = 0;
   int          degen_seen = 0;
   int          cycles = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Floor of a*b / 2^30, clamped to [-2^62, 2^62-1]
   function automatic longint qmul(longint a, longint b);
      logic signed [127:0] p;
      p = a * b;
      p = p >>> 30;
      if (p > 128'sd4611686018427387903) return 64'sd4611686018427387903;
      if (p < -128'sd4611686018427387904) return -64'sd4611686018427387904;
      return longint'(p);
   endfunction

   function automatic tensor_type predict_tensor(logic signed [15:0] vx,
                                                 logic signed [15:0] vy,
                                                 logic [15:0] cs2, logic [31:0] s,
                                                 logic [31:0] eta_s);
      tensor_type          t;
      longint              v[2], h[2][2], pr[2][2], tp[2][2], hph[2][2];
      longint              ph, phph, dd, sym, nn, num, corr, xx;
      logic [63:0]         eta;
      logic signed [159:0] w;
      int                  ai, aj, m, n;
      v[0] = vx;
      v[1] = vy;
      eta  = 64'(eta_s) * 64'(s);
      ph   = 0;
      phph = 0;
      // metric and projector
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            h[i][j]  = (i == j ? 64'sd1073741824 : 64'sd0) - v[i] * v[j];
            pr[i][j] = (h[i][j] * 32768 - longint'(cs2) * v[i] * v[j]) >>> 16;
         end
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            ph += qmul(pr[i][j], h[j][i]);
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            tp[i][j] = qmul(h[i][0], pr[0][j]) + qmul(h[i][1], pr[1][j]);
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            hph[i][j] = qmul(tp[i][0], h[0][j]) + qmul(tp[i][1], h[1][j]);
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            phph += qmul(pr[j][i], hph[i][j]);
      dd = qmul(ph, ph);
      t.degen = (dd == 0);
      // nine entries, ij and mn walking xx, xy, yy
      for (int p = 0; p < 3; p++) begin
         ai = (p == 2) ? 1 : 0;
         aj = (p == 0) ? 0 : 1;
         for (int r = 0; r < 3; r++) begin
            m = (r == 2) ? 1 : 0;
            n = (r == 0) ? 0 : 1;
            t.k[p*3+r] = '0;
            if (!t.degen) begin
               sym = h[ai][m] * h[aj][n] + h[ai][n] * h[aj][m];
               nn  = qmul(ph, hph[m][n]) - qmul(qmul(h[m][n], ph), hph[ai][aj]) + phph;
               num = qmul(h[ai][aj], nn);
               if (num > 64'sd68719476735) num = 64'sd68719476735;
               if (num < -64'sd68719476735) num = -64'sd68719476735;
               corr = (num * 64'sd67108864) / dd;
               xx   = (sym >>> 35) - corr;
               w    = xx * $signed({1'b0, eta});
               w    = w >>> 41;
               if (w > 160'sd140737488355327) w = 160'sd140737488355327;
               if (w < -160'sd140737488355328) w = -160'sd140737488355328;
               t.k[p*3+r] = w[KW-1:0];
            end
         end
      end
      return t;
   endfunction

   // Predict on every accepted request beat
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         tensor_q.push_back(predict_tensor(req_bus.vel_x, req_bus.vel_y,
                                           req_bus.sound_speed_sq, req_bus.entropy_density,
                                           visc_ratio_shadow));
   end

   // Check every accepted response beat against the oldest prediction
   always @(posedge clock) begin
      tensor_type exp_t;
      k_type      got[NK];
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.k_xx_xx, rsp_bus.k_xx_xy, rsp_bus.k_xx_yy,
                 rsp_bus.k_xy_xx, rsp_bus.k_xy_xy, rsp_bus.k_xy_yy,
                 rsp_bus.k_yy_xx, rsp_bus.k_yy_xy, rsp_bus.k_yy_yy};
         if (tensor_q.size() == 0) begin
            $display("%0t: response beat with nothing expected", $time);
            errors++;
         end else begin
            exp_t = tensor_q.pop_front();
            beats_checked++;
            if (rsp_bus.degenerate) degen_seen++;
            for (int e = 0; e < NK; e++)
               if (got[e] !== exp_t.k[e]) begin
                  $display("%0t: entry %0d expected %0d actual %0d",
                           $time, e, exp_t.k[e], got[e]);
                  errors++;
               end
            if (rsp_bus.degenerate !== exp_t.degen) begin
               $display("%0t: degenerate expected %0b actual %0b",
                        $time, exp_t.degen, rsp_bus.degenerate);
               errors++;
            end
         end
      end
   end

   // Response ready: long hold-off when requested, else random stalls
   always @(posedge clock) begin
      if (hold_len > 0) begin
         hold_len <= hold_len - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offer one cell and hold it until the beat is taken
   task automatic send_cell(logic [15:0] vx, logic [15:0] vy, logic [15:0] cs2,
                            logic [31:0] s);
      if ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_bus.valid           <= 1'b1;
      req_bus.vel_x           <= vx;
      req_bus.vel_y           <= vy;
      req_bus.sound_speed_sq  <= cs2;
      req_bus.entropy_density <= s;
      do @(posedge clock); while (!req_bus.ready);
      cells_sent++;
   endtask

   // Drop valid and wait for every predicted beat, plus the pipe depth
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tensor_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_eta(logic [31:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      visc_ratio_shadow = value;
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick32();
      case ($urandom_range(7))
         0: return 32'hFFFF_FFFF;
         1: return 32'h0000_0000;
         2: return 32'h0001_0000;
         default: return $urandom;
      endcase
   endfunction

   // Field extremes, superluminal corners and saturation at default ratio
   task automatic test_extremes();
      logic [15:0] vals[3] = '{16'h8000, 16'h0000, 16'h7FFF};
      idle_pct = 0; stall_pct = 0;
      foreach (vals[a])
         foreach (vals[b])
            send_cell(vals[a], vals[b], (a + b) % 2 ? 16'hFFFF : 16'h0000,
                      (a == b) ? 32'hFFFF_FFFF : 32'h0001_0000);
      send_cell(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
      send_cell(16'h4000, 16'hC000, 16'h5555, 32'h00A0_0000);
      drain();
   endtask

   // Register extremes: saturating and zero viscosity
   task automatic test_eta_extremes();
      write_eta(32'hFFFF_FFFF);
      send_cell(16'h7FFF, 16'h8000, 16'hFFFF, 32'hFFFF_FFFF);
      send_cell(16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
      send_cell(16'h1234, 16'hF00D, 16'h8000, 32'h0100_0000);
      write_eta(32'h0000_0000);
      send_cell(16'h7FFF, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_cell(16'h8000, 16'h0001, 16'h0001, 32'h0000_0001);
      write_eta(32'h0000_0001);
      send_cell(16'h8000, 16'h8000, 16'hFFFF, 32'hFFFF_FFFF);
      drain();
   endtask

   task automatic test_random_phase(int idle, int stall, int count);
      write_eta($urandom_range(3) == 0 ? $urandom : ETA_RESET + $urandom_range(65535));
      idle_pct = idle; stall_pct = stall;
      repeat (count) send_cell(pick16(), pick16(), pick16(), pick32());
      drain();
   endtask

   // Hold the response side off so the pipe fills and stalls the request side
   task automatic test_backpressure();
      idle_pct = 0; stall_pct = 0;
      hold_len = 300;
      repeat (80) send_cell(pick16(), pick16(), pick16(), pick32());
      drain();
   endtask

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_bus.valid = 1'b0;
      req_bus.vel_x = '0;
      req_bus.vel_y = '0;
      req_bus.sound_speed_sq  = '0;
      req_bus.entropy_density = '0;
      rsp_bus.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_eta_extremes();
      test_random_phase(0, 0, 240);
      test_random_phase(79, 0, 240);
      test_random_phase(0, 79, 240);
      test_random_phase(15, 15, 240);
      test_backpressure();
      write_eta(ETA_RESET);
      test_random_phase(15, 15, 40);

      if (tensor_q.size() != 0) begin
         $display("%0t: %0d predicted beats never arrived", $time, tensor_q.size());
         errors++;
      end
      $display("Covered %0d cells, %0d beats checked (%0d degenerate), over",
               cells_sent, beats_checked, degen_seen);
      $display("viscosity ratio extremes and four pacing mixes plus a long output stall.");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
